[rtl/wve_pkg.sv]
//------------------------------------------------------------------------------
// wve_pkg
// Shared types and constants for the wheel velocity estimator.
//------------------------------------------------------------------------------
`default_nettype none
package wve_pkg;

  localparam int unsigned AngleBitsDef = 12;
  localparam int unsigned WheelsDef    = 2;
  localparam int unsigned VelBits      = 40;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 20;
  localparam int unsigned ElecBits     = 12;

  // Register indexes
  localparam logic [CfgIdxBits-1:0] RegDir     = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegZero0   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegZero1   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegPoles   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegTau     = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegNominal = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegMaxGap  = 3'd6;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch input, form dt
    logic div_step;  // one step of the shared divider
    logic div_alpha; // load alpha division
    logic div_wheel; // load velocity division for the current wheel
    logic wheel_end; // finish current wheel (raw velocity done)
    logic filt;      // filter step for current wheel
    logic commit;    // commit state, build result
  } wve_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic reject;
    logic div_done;
  } wve_sts_t;

endpackage
`default_nettype wire

[rtl/wve_ctrl.sv]
//------------------------------------------------------------------------------
// wve_ctrl
// Sequencer: interval check, alpha division, per-wheel velocity division and
// filter steps, then result handoff.
//------------------------------------------------------------------------------
`default_nettype none
module wve_ctrl #(
  parameter int unsigned Wheels = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output wve_pkg::wve_cmd_t    cmd_o,
  output logic [$clog2(Wheels+1)-1:0] wheel_o,
  input  wire wve_pkg::wve_sts_t sts_i
);
  import wve_pkg::*;

  localparam int unsigned WB = $clog2(Wheels+1);

  typedef enum logic [2:0] {
    StIdle, StCheck, StAlpha, StWLoad, StWDiv, StFilt, StCommit, StOut
  } state_e;

  state_e        state_q;
  logic [WB-1:0] wheel_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign wheel_o     = wheel_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle:   cmd_o.start     = in_valid_i;
      StCheck:  cmd_o.div_alpha = !sts_i.reject;
      StAlpha:  cmd_o.div_step  = 1'b1;
      StWLoad:  cmd_o.div_wheel = 1'b1;
      StWDiv:   begin
        cmd_o.div_step  = !sts_i.div_done;
        cmd_o.wheel_end = sts_i.div_done;
      end
      StFilt:   cmd_o.filt      = 1'b1;
      StCommit: cmd_o.commit    = 1'b1;
      StOut:    ;
      default:  ;
    endcase
  end

  // State and wheel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wheel_q <= '0;
    end else begin
      unique case (state_q)
        StIdle:   if (in_valid_i) state_q <= StCheck;
        StCheck:  state_q <= sts_i.reject ? StCommit : StAlpha;
        StAlpha:  if (sts_i.div_done) begin
          wheel_q <= '0;
          state_q <= StWLoad;
        end
        StWLoad:  state_q <= StWDiv;
        StWDiv:   if (sts_i.div_done) state_q <= StFilt;
        StFilt:   begin
          if (wheel_q == WB'(Wheels - 1)) state_q <= StCommit;
          else begin
            wheel_q <= wheel_q + 1'b1;
            state_q <= StWLoad;
          end
        end
        StCommit: state_q <= StOut;
        StOut:    if (out_ready_i) state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/wve_datapath.sv]
//------------------------------------------------------------------------------
// wve_datapath
// Config registers, state, a shared radix-2 restoring divider and the
// filter and electrical angle arithmetic.
//------------------------------------------------------------------------------
`default_nettype none
module wve_datapath #(
  parameter int unsigned AngleBits = 12,
  parameter int unsigned Wheels    = 2
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [wve_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [wve_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic [Wheels*AngleBits-1:0] angles_i,
  input  wire logic [31:0]               time_i,
  input  wire wve_pkg::wve_cmd_t         cmd_i,
  input  wire logic [$clog2(Wheels+1)-1:0] wheel_i,
  output wve_pkg::wve_sts_t              sts_o,
  output logic                           status_o,
  output logic [Wheels*wve_pkg::VelBits-1:0]  vel_o,
  output logic [Wheels*wve_pkg::ElecBits-1:0] elec_o
);
  import wve_pkg::*;

  localparam int unsigned WB   = $clog2(Wheels+1);
  localparam int unsigned IB   = (Wheels > 1) ? $clog2(Wheels) : 1;
  localparam int unsigned DW   = AngleBits - 1 + 36;  // |delta|*256e6 width
  localparam int unsigned NB   = (DW > 48) ? DW : 48; // dividend width
  localparam int unsigned CB   = $clog2(NB + 1);
  localparam logic [27:0] VelScale = 28'd256000000;

  // Configuration
  logic [2*Wheels-1:0] dir_q;
  logic [11:0] zero_q [2];
  logic [5:0]  poles_q;
  logic [19:0] tau_q, gap_q;
  logic [15:0] nominal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= '0; zero_q[0] <= '0; zero_q[1] <= '0; poles_q <= 6'd7;
      tau_q <= 20'd5000; nominal_q <= 16'd1000; gap_q <= 20'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDir:     dir_q     <= (2*Wheels)'(cfg_data_i);
        RegZero0:   zero_q[0] <= cfg_data_i[11:0];
        RegZero1:   zero_q[1] <= cfg_data_i[11:0];
        RegPoles:   poles_q   <= cfg_data_i[5:0];
        RegTau:     tau_q     <= cfg_data_i;
        RegNominal: nominal_q <= cfg_data_i[15:0];
        RegMaxGap:  gap_q     <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Block state
  logic [AngleBits-1:0] last_q [Wheels];
  logic signed [VelBits-1:0] filt_q [Wheels];
  logic [31:0] last_time_q;
  logic        have_q;

  // Latched item
  logic [AngleBits-1:0] ang_q [Wheels];
  logic [31:0] now_q, dt_q;
  logic [16:0] alpha_q;
  logic signed [VelBits-1:0] next_q [Wheels];
  logic        neg_q;

  // Divider
  logic [NB-1:0] quo_q;
  logic [NB:0]   rem_q;
  logic [32:0]   den_q;
  logic [CB-1:0] cnt_q;
  logic [NB:0]   rem_sh, rem_sub;

  assign rem_sh  = {rem_q[NB-1:0], quo_q[NB-1]};
  assign rem_sub = rem_sh - (NB+1)'(den_q);

  logic [WB-1:0] w;
  logic [IB-1:0] wi;
  assign w  = wheel_i;
  assign wi = w[IB-1:0];
  logic [AngleBits-1:0] cur_a, cur_last, dlt;
  logic [AngleBits-1:0] mag;
  logic dneg, sgn;
  assign cur_a    = ang_q[wi];
  assign cur_last = last_q[wi];
  assign dlt  = have_q ? (cur_a - cur_last) : '0;
  assign dneg = dlt[AngleBits-1];
  assign mag  = dneg ? (~dlt + 1'b1) : dlt;
  assign sgn  = dneg ^ dir_q[w] ^ dir_q[w + WB'(Wheels)];

  logic [31:0] dt_new;
  assign dt_new = have_q ? (time_i - last_time_q) : 32'(nominal_q);
  assign sts_o.reject   = (dt_q == '0) || (dt_q > 32'(gap_q));
  assign sts_o.div_done = (cnt_q == '0);

  // Filter arithmetic
  logic signed [VelBits:0]    raw, err;
  logic signed [VelBits+18:0] prod;
  assign raw  = neg_q ? -$signed({1'b0, quo_q[VelBits-1:0]})
                      : $signed({1'b0, quo_q[VelBits-1:0]});
  assign err  = raw - (VelBits+1)'(filt_q[wi]);
  assign prod = err * $signed({1'b0, alpha_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < Wheels; i++) ang_q[i] <= angles_i[i*AngleBits +: AngleBits];
      now_q <= time_i;
      dt_q  <= dt_new;
    end
    if (cmd_i.div_alpha) begin
      quo_q <= NB'({dt_q, 16'd0});
      rem_q <= '0;
      den_q <= 33'(tau_q) + 33'(dt_q);
      cnt_q <= CB'(NB);
    end else if (cmd_i.div_wheel) begin
      // quotient still holds the filter factor when the first wheel loads
      if (w == '0) alpha_q <= quo_q[16:0];
      quo_q <= NB'(mag) * NB'(VelScale);
      rem_q <= '0;
      den_q <= 33'(dt_q);
      cnt_q <= CB'(NB);
      neg_q <= sgn;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      if (!rem_sub[NB]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NB-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.filt) next_q[wi] <= filt_q[wi] + VelBits'(prod >>> 16);
  end

  // State commit and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Wheels; i++) begin
        last_q[i] <= '0;
        filt_q[i] <= '0;
      end
      last_time_q <= '0;
      have_q      <= 1'b0;
    end else if (cmd_i.commit && !sts_o.reject) begin
      for (int i = 0; i < Wheels; i++) begin
        last_q[i] <= ang_q[i];
        filt_q[i] <= next_q[i];
      end
      last_time_q <= now_q;
      have_q      <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o <= sts_o.reject;
      for (int i = 0; i < Wheels; i++) begin
        logic [11:0] pr;
        pr = 12'(poles_q * 12'(ang_q[i]));
        if (dir_q[i]) pr = -pr;
        vel_o[i*VelBits +: VelBits]   <= sts_o.reject ? filt_q[i] : next_q[i];
        elec_o[i*ElecBits +: ElecBits] <= sts_o.reject ? '0 :
                                          (pr - ((i < 2) ? zero_q[i%2] : 12'd0));
      end
    end
  end
endmodule
`default_nettype wire

[rtl/wheel_velocity_estimator.sv]
//------------------------------------------------------------------------------
// wheel_velocity_estimator
// Two-wheel encoder velocity estimator with first-order low-pass filter.
//------------------------------------------------------------------------------
// One item at a time: a new input is taken only after the last result has
// been taken. A rejected interval skips the divider. An accepted sample
// is paced by the shared one-bit-per-cycle divider, used once for the
// filter factor and once per wheel for raw velocity. The result is held
// until taken.
`default_nettype none
module wheel_velocity_estimator #(
  parameter int unsigned ANGLE_BITS = wve_pkg::AngleBitsDef,
  parameter int unsigned WHEELS     = wve_pkg::WheelsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [wve_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [wve_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // angle_wheel0, angle_wheel1, ..., sample_time_us
  input  wire logic [((WHEELS*ANGLE_BITS+32+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // velocity_wheel0.., elec_angle_wheel0.. (status in tuser)
  output logic [((WHEELS*(wve_pkg::VelBits+wve_pkg::ElecBits)+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic      m_axis_tuser
);
  import wve_pkg::*;

  wve_cmd_t cmd;
  wve_sts_t sts;
  logic [$clog2(WHEELS+1)-1:0] wheel;
  logic [WHEELS*VelBits-1:0]  vel;
  logic [WHEELS*ElecBits-1:0] elec;

  wve_ctrl #(.Wheels(WHEELS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .wheel_o(wheel), .sts_i(sts)
  );

  wve_datapath #(.AngleBits(ANGLE_BITS), .Wheels(WHEELS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .angles_i(s_axis_tdata[WHEELS*ANGLE_BITS-1:0]),
    .time_i(s_axis_tdata[WHEELS*ANGLE_BITS +: 32]),
    .cmd_i(cmd), .wheel_i(wheel), .sts_o(sts),
    .status_o(m_axis_tuser), .vel_o(vel), .elec_o(elec)
  );

  assign m_axis_tdata = $bits(m_axis_tdata)'({elec, vel});
endmodule
`default_nettype wire
